>>> design/msort_pkg.sv
// msort_pkg: shared constants for the merge sort engine
// no dependencies; imported by msort_ram, msort_ctrl, merge_sort_engine, msort_props, msort_checker and the bench

package msort_pkg;

  localparam int unsigned DEPTH_DEF   = 64;  // default batch capacity
  localparam int unsigned VALUE_W     = 32;  // width of one element
  localparam int unsigned IN_TDATA_W  = 32;  // value, byte aligned
  localparam int unsigned OUT_TDATA_W = 32;  // sorted_value, byte aligned
  localparam int unsigned OUT_TUSER_W = 1;   // overflow

endpackage

>>> design/merge_sort_engine.sv
// merge_sort_engine: takes a batch of signed 32-bit words, the word with tlast
// closes it, then returns the batch sorted ascending (stable), last word marked.
// Words beyond DEPTH are dropped and every result of that batch has tuser set.
// For a batch of n words: loading takes one word whenever one is offered. Sorting
// runs ceil(log2 n) bottom-up merge passes between two memory banks; each pass
// has a set-up step for each merged run pair, the merge loop producing one word a
// cycle from the two read ports of the source bank. Emitting reads each word into
// the output register before it issues the next read, as the memory reads are
// registered. No input is taken from the closing word until the last result has
// been handed over.
// depends on msort_pkg, msort_ram, msort_ctrl

module merge_sort_engine
  import msort_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic                   s_tlast,   // is_last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                   m_tlast,   // is_last_res
  output logic [OUT_TUSER_W-1:0] m_tuser    // [0] overflow
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic               we0;
  logic               we1;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic [VALUE_W-1:0] rd0_a;
  logic [VALUE_W-1:0] rd0_b;
  logic [VALUE_W-1:0] rd1_a;
  logic [VALUE_W-1:0] rd1_b;
  logic [VALUE_W-1:0] m_value;
  logic               m_ovf;

  msort_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_value  (s_tdata[VALUE_W-1:0]),
    .s_last   (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_value  (m_value),
    .m_last   (m_tlast),
    .m_ovf    (m_ovf),
    .we0      (we0),
    .we1      (we1),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .rd0_a    (rd0_a),
    .rd0_b    (rd0_b),
    .rd1_a    (rd1_a),
    .rd1_b    (rd1_b)
  );

  // bank 0 takes the loaded batch, the banks then alternate pass by pass
  msort_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  msort_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  assign m_tdata = OUT_TDATA_W'(m_value);
  assign m_tuser = OUT_TUSER_W'(m_ovf);

endmodule

>>> design/msort_ram.sv
// msort_ram: element memory, one write port and two registered read ports
// depends on msort_pkg for the element width

module msort_ram
  import msort_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr_a,
  input  logic [AW-1:0]      raddr_b,
  output logic [VALUE_W-1:0] rdata_a,
  output logic [VALUE_W-1:0] rdata_b
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> design/msort_ctrl.sv
// msort_ctrl: load, bottom-up merge pass sequencer and emit control
// depends on msort_pkg; drives the two msort_ram instances in ping-pong

module msort_ctrl
  import msort_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_value,
  input  logic               s_last,
  // result words
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_value,
  output logic               m_last,
  output logic               m_ovf,
  // memory ports
  output logic               we0,
  output logic               we1,
  output logic [AW-1:0]      waddr,
  output logic [VALUE_W-1:0] wdata,
  output logic [AW-1:0]      raddr_a,
  output logic [AW-1:0]      raddr_b,
  input  logic [VALUE_W-1:0] rd0_a,
  input  logic [VALUE_W-1:0] rd0_b,
  input  logic [VALUE_W-1:0] rd1_a,
  input  logic [VALUE_W-1:0] rd1_b
);

  localparam int unsigned XW = CW + 2;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SETUP,
    S_MERGE,
    S_EMIT
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic               ovf;
  logic [CW-1:0]      n;
  logic [XW-1:0]      w;
  logic [XW-1:0]      lo;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      i;
  logic [CW-1:0]      j;
  logic [CW-1:0]      k;
  logic               src;
  logic               pend;
  logic               ovalid;
  logic [VALUE_W-1:0] odata;
  logic               olast;

  logic               accept;
  logic               room;
  logic [CW-1:0]      n_load;
  logic [XW-1:0]      n_x;
  logic [XW-1:0]      w2;
  logic [XW-1:0]      mid_x;
  logic [XW-1:0]      hi_x;
  logic [CW-1:0]      mid_c;
  logic [CW-1:0]      hi_c;
  logic [VALUE_W-1:0] rd_a;
  logic [VALUE_W-1:0] rd_b;
  logic               take_l;
  logic [CW-1:0]      i_next;
  logic [CW-1:0]      j_next;
  logic [CW-1:0]      k_next;
  logic [XW-1:0]      lo_next;
  logic               issue;
  logic               out_take;

  assign s_tready = (state == S_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign room     = (count < CW'(DEPTH));
  assign n_load   = room ? count + CW'(1) : count;

  assign n_x   = XW'(n);
  assign w2    = w << 1;
  assign mid_x = lo + w;
  assign hi_x  = lo + w2;
  assign mid_c = (mid_x < n_x) ? mid_x[CW-1:0] : n;
  assign hi_c  = (hi_x < n_x) ? hi_x[CW-1:0] : n;

  assign rd_a = src ? rd1_a : rd0_a;
  assign rd_b = src ? rd1_b : rd0_b;

  // left run wins ties, so the sort stays stable
  assign take_l = (i < mid) && ((j >= hi) || ($signed(rd_a) <= $signed(rd_b)));
  assign i_next  = i + CW'(take_l);
  assign j_next  = j + CW'(!take_l);
  assign k_next  = k + CW'(1);
  assign lo_next = lo + w2;

  assign out_take = ovalid && m_tready;
  assign issue    = (state == S_EMIT) && !pend && (k < n) && (!ovalid || m_tready);

  always_comb begin
    we0     = 1'b0;
    we1     = 1'b0;
    waddr   = k[AW-1:0];
    wdata   = take_l ? rd_a : rd_b;
    raddr_a = k[AW-1:0];
    raddr_b = j_next[AW-1:0];
    unique case (state)
      S_LOAD: begin
        we0   = accept && room;
        waddr = count[AW-1:0];
        wdata = s_value;
      end
      S_SETUP: begin
        raddr_a = lo[AW-1:0];
        raddr_b = mid_c[AW-1:0];
      end
      S_MERGE: begin
        // merge writes go to the other bank
        we0     = src;
        we1     = !src;
        raddr_a = i_next[AW-1:0];
        raddr_b = j_next[AW-1:0];
      end
      S_EMIT: begin
        raddr_a = k[AW-1:0];
      end
      default: begin
        raddr_a = k[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      count  <= '0;
      ovf    <= 1'b0;
      pend   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_last) begin
              n    <= n_load;
              w    <= XW'(1);
              lo   <= '0;
              src  <= 1'b0;
              k    <= '0;
              pend <= 1'b0;
              state <= (n_load > CW'(1)) ? S_SETUP : S_EMIT;
            end
          end
        end
        S_SETUP: begin
          i     <= lo[CW-1:0];
          j     <= mid_c;
          k     <= lo[CW-1:0];
          mid   <= mid_c;
          hi    <= hi_c;
          state <= S_MERGE;
        end
        S_MERGE: begin
          i <= i_next;
          j <= j_next;
          if (k_next == hi) begin
            if (lo_next >= n_x) begin
              // pass finished, swap banks
              w   <= w2;
              src <= !src;
              lo  <= '0;
              k   <= '0;
              state <= (w2 >= n_x) ? S_EMIT : S_SETUP;
            end else begin
              lo    <= lo_next;
              state <= S_SETUP;
            end
          end else begin
            k <= k_next;
          end
        end
        S_EMIT: begin
          // a read is only issued once the output register is free
          if (pend) begin
            odata  <= rd_a;
            olast  <= (k == n);
            ovalid <= 1'b1;
            pend   <= 1'b0;
          end else if (out_take) begin
            ovalid <= 1'b0;
          end
          if (issue) begin
            k    <= k_next;
            pend <= 1'b1;
          end
          if (out_take && olast) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign m_tvalid = ovalid;
  assign m_value  = odata;
  assign m_last   = olast;
  assign m_ovf    = ovf;

endmodule

>>> design/msort_checker.sv
// msort_props: port-level assertions for merge_sort_engine, bound to the top
// depends on msort_pkg for port widths

module msort_props
  import msort_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tlast,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic                   m_tlast,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  // a pending result word is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word withdrawn while stalled");

  // input and output phases never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while a result is pending");

  // closing word starts the sort, input closes
  a_close: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still open after closing word");

  // last result hands back to loading
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("input not reopened after last result");

  // overflow flag is the same across one batch of results
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
    else $error("overflow flag changed inside a batch");

endmodule

bind merge_sort_engine msort_props u_msort_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

>>> sim/msort_checker.sv
// msort_checker: watches both stream ports of merge_sort_engine, predicts each
// sorted batch from the words taken in and compares every result word with it
// depends on msort_pkg

module msort_checker
  import msort_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic                   s_tlast,   // is_last
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] sorted_value
  input  logic                   m_tlast,   // is_last_res
  input  logic [OUT_TUSER_W-1:0] m_tuser,   // [0] overflow
  output int                     mismatch_count,
  output int                     pending
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      ovf;
  } sorted_word_t;

  sorted_word_t              sorted_due[$];
  logic signed [VALUE_W-1:0] batch[DEPTH];
  int                        batch_len;
  logic                      batch_ovf;
  int                        errors;

  task automatic report(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  // stable ascending sort of the stored batch, queued as the words to come
  task automatic close_batch();
    int i;
    int j;
    logic signed [VALUE_W-1:0] key;
    sorted_word_t w;
    for (i = 1; i < batch_len; i++) begin
      key = batch[i];
      j = i - 1;
      while (j >= 0 && batch[j] > key) begin
        batch[j + 1] = batch[j];
        j--;
      end
      batch[j + 1] = key;
    end
    for (i = 0; i < batch_len; i++) begin
      w.value = batch[i];
      w.last  = (i == batch_len - 1);
      w.ovf   = batch_ovf;
      sorted_due.push_back(w);
    end
    batch_len = 0;
    batch_ovf = 1'b0;
  endtask

  task automatic take_word(input logic [VALUE_W-1:0] v, input logic closing);
    if (batch_len < DEPTH) begin
      batch[batch_len] = v;
      batch_len++;
    end else begin
      batch_ovf = 1'b1;
    end
    if (closing) close_batch();
  endtask

  task automatic check_word();
    sorted_word_t want;
    if (sorted_due.size() == 0) begin
      report($sformatf("result word %0d with nothing expected", $signed(m_tdata)));
    end else begin
      want = sorted_due.pop_front();
      if (m_tdata[VALUE_W-1:0] !== want.value)
        report($sformatf("sorted value %0d, expected %0d",
                         $signed(m_tdata[VALUE_W-1:0]), want.value));
      if (m_tlast !== want.last)
        report($sformatf("tlast %b, expected %b on value %0d",
                         m_tlast, want.last, want.value));
      if (m_tuser[0] !== want.ovf)
        report($sformatf("overflow %b, expected %b on value %0d",
                         m_tuser[0], want.ovf, want.value));
    end
  endtask

  initial begin
    errors = 0;
    batch_len = 0;
    batch_ovf = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      batch_len = 0;
      batch_ovf = 1'b0;
      sorted_due.delete();
    end else begin
      // results first: a batch closed at this edge only yields words later
      if (m_tvalid && m_tready) check_word();
      if (s_tvalid && s_tready) take_word(s_tdata[VALUE_W-1:0], s_tlast);
    end
    mismatch_count <= errors;
    pending <= sorted_due.size();
  end

endmodule

>>> sim/tb_merge_sort_engine.sv
// tb_merge_sort_engine: drives batches of signed words into merge_sort_engine
// under varying stalls on both ports and reports the verdict from the checker
// depends on msort_pkg, merge_sort_engine, msort_checker

module tb_merge_sort_engine;
  import msort_pkg::*;

  localparam int unsigned CAPACITY    = DEPTH_DEF;
  localparam int          HOLD_CYCLES = 400;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [31:0] value
  logic                   s_tlast;   // is_last
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] sorted_value
  logic                   m_tlast;   // is_last_res
  logic [OUT_TUSER_W-1:0] m_tuser;   // [0] overflow

  int mismatch_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_asked;
  int holds_granted;

  merge_sort_engine #(.DEPTH(CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  msort_checker #(.DEPTH(CAPACITY)) u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .mismatch_count(mismatch_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly random values, with extremes and a narrow range for duplicates
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom_range(8) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [VALUE_W-1:0] v, input logic closing);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= closing;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
  endtask

  // receiver: random back-pressure, or a long hold whenever one is asked for
  initial begin
    m_tready <= 1'b0;
    holds_granted = 0;
    forever begin
      @(posedge clk);
      if (holds_granted != holds_asked) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_granted++;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #400000;
    $display("tb_merge_sort_engine failed");
    $finish;
  end

  initial begin
    logic [VALUE_W-1:0] mixed[8];
    int sent;
    int len;
    mixed = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
              32'h1, 32'h5, 32'hffff_ffff, 32'h7fff_ffff};
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    s_tlast       <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    holds_asked   <= 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single-word batch, a mixed batch with ties and extremes, a reversed pair
    send_word(32'h8000_0000, 1'b1);
    for (int i = 0; i < 8; i++) send_word(mixed[i], i == 7);
    send_word(32'd3, 1'b0);
    send_word(-32'sd3, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct <= 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct <= 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      sent = 0;
      while (sent < 17) begin
        len = $urandom_range(8, 1);
        send_batch(len);
        sent += len;
      end
      case (phase)
        0: send_batch(CAPACITY);                          // exactly full
        1: send_batch(CAPACITY + $urandom_range(3, 1));   // words dropped
        default: begin
          // output held back while batches keep coming, so the input stalls
          holds_asked <= holds_asked + 1;
          repeat (4) send_batch($urandom_range(8, 2));
        end
      endcase
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_merge_sort_engine passed");
    end else begin
      $display("tb_merge_sort_engine failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/msort_pkg.sv
design/msort_ram.sv
design/msort_ctrl.sv
design/merge_sort_engine.sv
design/msort_checker.sv
sim/msort_checker.sv
sim/tb_merge_sort_engine.sv
